// ----- rtl/core/range_max_manhattan_distance_core_assert.svh -----
// Assertion macros for the range max Manhattan distance core.
// Included by the top level; no other dependencies.
`ifndef RANGE_MAX_MANHATTAN_DISTANCE_CORE_ASSERT_SVH
`define RANGE_MAX_MANHATTAN_DISTANCE_CORE_ASSERT_SVH
// Check that a condition implies another at the same edge.
`define RMMD_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Check that a condition implies another at the next edge.
`define RMMD_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ----- rtl/core/rmmd_pkg.sv -----
// Shared types and constants for the range max Manhattan distance core.
// No dependencies.
`timescale 1ns / 1ps
package rmmd_pkg;
    localparam int unsigned LEAVES_DEF     = 1024;
    localparam int unsigned COORD_BITS_DEF = 30;
    localparam int unsigned CNT_W          = 11;
    localparam int unsigned IDX_W          = 10;
    localparam int unsigned FLD_W          = 30;
    localparam int unsigned DIST_W         = 31;
    localparam logic [31:0] EMPTY_SUM      = 32'hFFFF_FFFF;
    localparam logic [31:0] DIFF_TOP       = 32'h7FFF_FFFF;
    localparam logic [31:0] DIFF_BOTTOM    = 32'h8000_0000;
    localparam logic        CMD_WRITE      = 1'b0;
    localparam logic        CMD_QUERY      = 1'b1;

    // Four aggregates of one node.
    typedef struct packed {
        logic [31:0] smin;
        logic [31:0] smax;
        logic [31:0] dmin;
        logic [31:0] dmax;
    } t_agg;

    localparam t_agg AGG_EMPTY = '{EMPTY_SUM, 32'd0, DIFF_TOP, DIFF_BOTTOM};

    // Commands from controller to datapath.
    typedef struct packed {
        logic clr;      // write one empty node of the clearing pass
        logic load;     // capture input word
        logic rd;       // issue memory read at current node(s)
        logic wr_leaf;  // write leaf from captured point
        logic wr_node;  // write combined children at parent
        logic acc;      // fold read data into accumulator
        logic step;     // advance lo/hi pointers
        logic fin;      // compute result into output register
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic clr_done;   // clearing pass is at its last node
        logic is_query;
        logic skip;       // write out of range or query trivially empty
        logic at_root;    // write walk reached the root
        logic range_done; // lo >= hi
    } t_sts;

    function automatic t_agg agg_merge(input t_agg a, input t_agg b);
        t_agg r;
        r.smin = (a.smin < b.smin) ? a.smin : b.smin;
        r.smax = (a.smax > b.smax) ? a.smax : b.smax;
        r.dmin = ($signed(a.dmin) < $signed(b.dmin)) ? a.dmin : b.dmin;
        r.dmax = ($signed(a.dmax) > $signed(b.dmax)) ? a.dmax : b.dmax;
        return r;
    endfunction
endpackage

// ----- rtl/core/rmmd_ctrl.sv -----
// Controller state machine for the range max Manhattan distance core.
// Depends on rmmd_pkg.
`timescale 1ns / 1ps
module rmmd_ctrl
    import rmmd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_WRD   = 3'd2;
    localparam logic [2:0] S_WWR   = 3'd3;
    localparam logic [2:0] S_QRD   = 3'd4;
    localparam logic [2:0] S_QACC  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;
    localparam logic [2:0] S_CLR   = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    // Clear the node memory after reset, then sequence one word through write walk or range walk.
    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd    = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (!i_sts.is_query) begin
                    if (i_sts.skip) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.wr_leaf = 1'b1;
                        n_state       = S_WRD;
                    end
                end else if (i_sts.skip) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_QRD;
                end
            end
            S_WRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WWR;
            end
            S_WWR: begin
                o_cmd.wr_node = 1'b1;
                o_cmd.step    = 1'b1;
                n_state       = i_sts.at_root ? S_IDLE : S_WRD;
            end
            S_QRD: begin
                if (i_sts.range_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_QACC;
                end
            end
            S_QACC: begin
                o_cmd.acc  = 1'b1;
                o_cmd.step = 1'b1;
                n_state    = S_QRD;
            end
            S_FIN: begin
                // Hold until the output register is free.
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.fin = 1'b1;
                    n_ovalid  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end
endmodule

// ----- rtl/core/rmmd_dp.sv -----
// Datapath for the range max Manhattan distance core: node memories with
// a clearing pass after reset, pointers, accumulator and result. Uses rmmd_pkg.
`timescale 1ns / 1ps
module rmmd_dp
    import rmmd_pkg::*;
#(
    parameter int unsigned LEAVES     = LEAVES_DEF,
    parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [CNT_W-1:0]  i_cfg_data,
    input  logic              i_cmd_bit,
    input  logic [IDX_W-1:0]  i_point_index,
    input  logic [FLD_W-1:0]  i_coord_x,
    input  logic [FLD_W-1:0]  i_coord_y,
    input  logic [IDX_W-1:0]  i_range_first,
    input  logic [IDX_W-1:0]  i_range_last,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic [DIST_W-1:0] o_max_distance,
    output logic              o_empty_range
);
    localparam int unsigned LW = $clog2(LEAVES);
    localparam int unsigned NW = LW + 1;          // node address bits
    localparam int unsigned PW = NW + 1;          // pointer with headroom
    localparam int unsigned RW = (LW > IDX_W) ? LW : IDX_W;
    localparam logic [PW-1:0] LEAF_BASE = PW'(LEAVES);

    // Node memory; every node is set empty by the clearing pass after reset.
    logic [127:0] r_mem_a [0:(1<<NW)-1];
    logic [127:0] r_mem_b [0:(1<<NW)-1];
    logic [NW-1:0] r_clr_addr;
    logic [127:0] r_rd_a, r_rd_b;

    logic [CNT_W-1:0] r_pcount;
    logic             r_isq;
    logic [PW-1:0]    r_lo, r_hi;
    logic [31:0]      r_qsum, r_qdiff;
    t_agg             r_acc;
    logic [DIST_W-1:0] r_dist;
    logic             r_empty;
    logic             r_skip;
    t_agg             r_leaf;

    // Used count and masked coordinates.
    logic [CNT_W-1:0] used;
    logic [31:0]      mx, my;
    logic [RW:0]      last_c, first_c;
    assign used = (32'(r_pcount) < LEAVES) ? r_pcount : CNT_W'(LEAVES);
    assign mx   = 32'(i_coord_x) & ((32'd1 << COORD_BITS) - 32'd1);
    assign my   = 32'(i_coord_y) & ((32'd1 << COORD_BITS) - 32'd1);
    assign first_c = (RW+1)'(i_range_first);
    assign last_c  = ((RW+1)'(i_range_last) > (RW+1)'(used) - 1'b1)
                   ? (RW+1)'(used) - 1'b1 : (RW+1)'(i_range_last);

    // Memory addresses: write walk reads both children of lo>>1.
    logic [NW-1:0] addr_a, addr_b;
    logic          use_lo, use_hi;
    assign use_lo = r_lo[0];
    assign use_hi = r_hi[0];
    always_comb begin
        if (!r_isq) begin
            addr_a = NW'({r_lo[PW-1:1], 1'b0});
            addr_b = NW'({r_lo[PW-1:1], 1'b1});
        end else begin
            addr_a = NW'(r_lo);
            addr_b = NW'(r_hi - 1'b1);
        end
    end

    t_agg va, vb, comb;
    assign va   = t_agg'(r_rd_a);
    assign vb   = t_agg'(r_rd_b);
    assign comb = agg_merge(va, vb);

    // Two copies so both children / both ends read in the same cycle.
    logic          we;
    logic [NW-1:0] waddr;
    logic [127:0]  wdata;
    assign we    = i_cmd.clr || i_cmd.wr_leaf || i_cmd.wr_node;
    assign waddr = i_cmd.clr ? r_clr_addr
                 : (i_cmd.wr_leaf ? NW'(r_lo) : NW'(r_lo >> 1));
    assign wdata = i_cmd.clr ? AGG_EMPTY : (i_cmd.wr_leaf ? r_leaf : comb);

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem_a[waddr] <= wdata;
            r_mem_b[waddr] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rd_a <= r_mem_a[addr_a];
            r_rd_b <= r_mem_b[addr_b];
        end
    end

    // Final distance: four candidates, clamp at zero and at max.
    logic signed [33:0] c0, c1, c2, c3, b01, b23, best;
    always_comb begin
        c0   = $signed({2'b0, r_qsum}) - $signed({2'b0, r_acc.smin});
        c1   = $signed({2'b0, r_acc.smax}) - $signed({2'b0, r_qsum});
        c2   = $signed({{2{r_acc.dmax[31]}}, r_acc.dmax})
             - $signed({{2{r_qdiff[31]}}, r_qdiff});
        c3   = $signed({{2{r_qdiff[31]}}, r_qdiff})
             - $signed({{2{r_acc.dmin[31]}}, r_acc.dmin});
        b01  = (c1 > c0) ? c1 : c0;
        b23  = (c3 > c2) ? c3 : c2;
        best = (b23 > b01) ? b23 : b01;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount   <= CNT_W'(1024);
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_pcount <= i_cfg_data;
            end
            // Advance the clearing pass.
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
        // Capture a word and decide trivial cases.
        if (i_cmd.load) begin
            r_isq   <= i_cmd_bit;
            r_qsum  <= mx + my;
            r_qdiff <= mx - my;
            r_leaf  <= '{mx + my, mx + my, mx - my, mx - my};
            r_acc   <= AGG_EMPTY;
            if (i_cmd_bit == CMD_WRITE) begin
                r_skip <= (CNT_W'(i_point_index) >= used);
                r_lo   <= LEAF_BASE + PW'(i_point_index);
            end else begin
                r_skip <= (used == '0) || (first_c > last_c);
                r_lo   <= LEAF_BASE + PW'(i_range_first);
                r_hi   <= LEAF_BASE + PW'(last_c) + 1'b1;
            end
        end
        if (i_cmd.acc) begin
            r_acc <= agg_merge(agg_merge(r_acc, use_lo ? va : AGG_EMPTY),
                               use_hi ? vb : AGG_EMPTY);
        end
        if (i_cmd.step) begin
            if (!r_isq) begin
                r_lo <= r_lo >> 1;
            end else begin
                r_lo <= (r_lo + PW'(use_lo)) >> 1;
                r_hi <= (r_hi - PW'(use_hi)) >> 1;
            end
        end
        if (i_cmd.fin) begin
            if (r_skip || r_acc.smin == EMPTY_SUM) begin
                r_dist  <= '0;
                r_empty <= 1'b1;
            end else begin
                r_empty <= 1'b0;
                if (best < 0)
                    r_dist <= '0;
                else if (best > 34'sh7FFF_FFFF)
                    r_dist <= {DIST_W{1'b1}};
                else
                    r_dist <= best[DIST_W-1:0];
            end
        end
    end

    assign o_sts.clr_done   = &r_clr_addr;
    assign o_sts.is_query   = r_isq;
    assign o_sts.skip       = r_skip;
    assign o_sts.at_root    = (r_lo >> 1) == PW'(1);
    assign o_sts.range_done = (r_lo >= r_hi);
    assign o_max_distance   = r_dist;
    assign o_empty_range    = r_empty;
endmodule

// ----- rtl/core/range_max_manhattan_distance_core.sv -----
// Range max Manhattan distance core. After reset a clearing pass sets every
// node empty before the first word is taken. A write stores the leaf, then
// reads both children and writes the parent at each tree level up to the
// root; a query reads and folds the nodes at each tree level visited, paced
// by the node memory read, and a trivially empty query goes straight to the
// result. A finished query waits while the previous result is still unaccepted.
// Depends on rmmd_pkg, rmmd_ctrl, rmmd_dp.
`timescale 1ns / 1ps
`include "range_max_manhattan_distance_core_assert.svh"
module range_max_manhattan_distance_core
    import rmmd_pkg::*;
#(
    parameter int unsigned LEAVES     = LEAVES_DEF,
    parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [15:0]  i_cfg_data,     // point_count[10:0]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // point_index, coord_x, coord_y,
                                         // range_first, range_last
    input  logic         s_axis_tuser,   // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // max_distance
    output logic         m_axis_tuser    // empty_range
);
    t_cmd cmd;
    t_sts sts;
    logic [DIST_W-1:0] max_dist;

    assign o_cfg_ready = 1'b1;

    rmmd_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_out_ready(m_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rmmd_dp #(.LEAVES(LEAVES), .COORD_BITS(COORD_BITS)) u_dp (
        .i_clk, .i_rst_n,
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data[CNT_W-1:0]),
        .i_cmd_bit     (s_axis_tuser),
        .i_point_index (s_axis_tdata[9:0]),
        .i_coord_x     (s_axis_tdata[39:10]),
        .i_coord_y     (s_axis_tdata[69:40]),
        .i_range_first (s_axis_tdata[79:70]),
        .i_range_last  (s_axis_tdata[89:80]),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_max_distance(max_dist),
        .o_empty_range (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, max_dist};

    `RMMD_ASSERT_IMP(a_empty_zero, m_axis_tvalid && m_axis_tuser, max_dist == '0)
    `RMMD_ASSERT_NEXT(a_no_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

// ----- verif/range_max_manhattan_distance_core_tb.sv -----
// Testbench for range_max_manhattan_distance_core: drives point writes and range
// queries over a stream port, predicts each query result from its own tree copy.
// Depends on rmmd_pkg and the core RTL.
`timescale 1ns / 1ps
module range_max_manhattan_distance_core_tb;
    import rmmd_pkg::*;

    localparam int unsigned NODE_CNT = 2 * LEAVES_DEF;
    localparam logic [29:0] COORD_TOP = 30'h3FFF_FFFF;

    typedef struct {
        logic [30:0] distance;
        logic        empty;
    } t_dist;

    // Scoreboard: own segment tree plus queue of expected query results
    class dist_scoreboard;
        logic [31:0] sum_lo [NODE_CNT];
        logic [31:0] sum_hi [NODE_CNT];
        logic [31:0] dif_lo [NODE_CNT];
        logic [31:0] dif_hi [NODE_CNT];
        logic [10:0] point_count;
        t_dist       pending_q[$];
        int          mismatches;
        int          checked;

        function new();
            for (int i = 0; i < NODE_CNT; i++) begin
                sum_lo[i] = EMPTY_SUM;
                sum_hi[i] = 32'd0;
                dif_lo[i] = DIFF_TOP;
                dif_hi[i] = DIFF_BOTTOM;
            end
            point_count = 11'd1024;
            mismatches = 0;
            checked = 0;
        endfunction

        function int unsigned in_use();
            return (point_count < LEAVES_DEF) ? point_count : LEAVES_DEF;
        endfunction

        // Fold one node into the running aggregate
        function void fold(int n, inout logic [31:0] smn, inout logic [31:0] smx,
                           inout logic [31:0] dmn, inout logic [31:0] dmx);
            if (sum_lo[n] < smn) smn = sum_lo[n];
            if (sum_hi[n] > smx) smx = sum_hi[n];
            if ($signed(dif_lo[n]) < $signed(dmn)) dmn = dif_lo[n];
            if ($signed(dif_hi[n]) > $signed(dmx)) dmx = dif_hi[n];
        endfunction

        // Note an accepted input word; queries push one expected result
        function void note_word(logic cmd, logic [9:0] idx, logic [29:0] x, logic [29:0] y,
                                logic [9:0] first, logic [9:0] last);
            int unsigned cnt;
            logic [31:0] qs, qd, smn, smx, dmn, dmx;
            int lo, hi, n;
            longint best, c;
            t_dist res;
            cnt = in_use();
            qs = {2'b0, x} + {2'b0, y};
            qd = {2'b0, x} - {2'b0, y};
            if (cmd == CMD_WRITE) begin
                if (idx >= cnt) return;
                n = LEAVES_DEF + idx;
                sum_lo[n] = qs; sum_hi[n] = qs; dif_lo[n] = qd; dif_hi[n] = qd;
                n = n >> 1;
                while (n >= 1) begin
                    smn = EMPTY_SUM; smx = 0; dmn = DIFF_TOP; dmx = DIFF_BOTTOM;
                    fold(2 * n, smn, smx, dmn, dmx);
                    fold(2 * n + 1, smn, smx, dmn, dmx);
                    sum_lo[n] = smn; sum_hi[n] = smx; dif_lo[n] = dmn; dif_hi[n] = dmx;
                    n = n >> 1;
                end
                return;
            end
            res.distance = '0;
            res.empty = 1'b1;
            if (cnt != 0) begin
                if (last > cnt - 1) last = 10'(cnt - 1);
                if (first <= last) begin
                    smn = EMPTY_SUM; smx = 0; dmn = DIFF_TOP; dmx = DIFF_BOTTOM;
                    lo = LEAVES_DEF + first;
                    hi = LEAVES_DEF + last + 1;
                    while (lo < hi) begin
                        if (lo & 1) begin fold(lo, smn, smx, dmn, dmx); lo++; end
                        if (hi & 1) begin hi--; fold(hi, smn, smx, dmn, dmx); end
                        lo = lo >> 1;
                        hi = hi >> 1;
                    end
                    if (smn != EMPTY_SUM) begin
                        best = longint'(qs) - longint'(smn);
                        c = longint'(smx) - longint'(qs);
                        if (c > best) best = c;
                        c = longint'($signed(dmx)) - longint'($signed(qd));
                        if (c > best) best = c;
                        c = longint'($signed(qd)) - longint'($signed(dmn));
                        if (c > best) best = c;
                        if (best < 0) best = 0;
                        if (best > 64'h7FFF_FFFF) best = 64'h7FFF_FFFF;
                        res.distance = best[30:0];
                        res.empty = 1'b0;
                    end
                end
            end
            pending_q.push_back(res);
        endfunction

        // Compare one result word against the oldest expectation
        function void check_result(logic [31:0] data, logic empty);
            t_dist exp_r;
            checked++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: dist %0d empty %0b", data, empty);
                return;
            end
            exp_r = pending_q.pop_front();
            if (data !== {1'b0, exp_r.distance} || empty !== exp_r.empty) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected dist %0d empty %0b, got dist %0d empty %0b",
                             exp_r.distance, exp_r.empty, data, empty);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    dist_scoreboard sb;
    bit  steady_mode = 1'b0;  // no idling on either side
    int  holdoff_cycles = 0;  // receiver hold-off still to run
    int  writes_sent = 0;
    int  queries_sent = 0;

    range_max_manhattan_distance_core u_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: random stalls, plus a counted long hold-off
    always @(negedge i_clk) begin
        if (holdoff_cycles > 0) begin
            holdoff_cycles--;
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = steady_mode || ($urandom_range(99) >= 22);
        end
    end

    // Check every accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Offer one word and hold it until accepted
    task automatic send_word(logic cmd, logic [9:0] idx, logic [29:0] x, logic [29:0] y,
                             logic [9:0] first, logic [9:0] last);
        logic [95:0] packed_w;
        packed_w = {6'b0, last, first, y, x, idx};
        @(negedge i_clk);
        while (!steady_mode && $urandom_range(99) < 22) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = packed_w;
        s_axis_tuser = cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(cmd, idx, x, y, first, last);
        if (cmd == CMD_WRITE) writes_sent++; else queries_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Wait for every expected result, then let a trailing write finish
    task automatic drain();
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_count(logic [10:0] cnt);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = {5'b0, cnt};
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.point_count = cnt;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [29:0] rand_coord();
        case ($urandom_range(9))
            0: return '0;
            1: return COORD_TOP;
            2: return 30'($urandom_range(255));
            default: return 30'($urandom);
        endcase
    endfunction

    // One random word: mostly in-range writes and queries, some noise
    task automatic send_random();
        int unsigned cnt;
        logic [9:0] idx, first, last;
        cnt = sb.in_use();
        idx = 10'($urandom);
        first = 10'($urandom);
        last = 10'($urandom);
        if (cnt > 0 && $urandom_range(9) != 0) begin
            idx = 10'($urandom_range(cnt - 1));
            first = 10'($urandom_range(cnt - 1));
            if ($urandom_range(3) == 0) last = first;
            else if ($urandom_range(9) != 0)
                last = 10'($urandom_range(1023 < first + 300 ? 1023 : first + 300, first));
        end
        send_word($urandom_range(99) < 45 ? CMD_WRITE : CMD_QUERY, idx, rand_coord(),
                  rand_coord(), first, last);
    endtask

    initial begin
        logic [10:0] counts[6] = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd37, 11'd1024};
        int per_phase[6] = '{420, 80, 60, 420, 300, 420};
        sb = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty tree, corner points, reversed and single ranges
        send_word(CMD_QUERY, 0, 0, 0, 0, 1023);
        send_word(CMD_WRITE, 0, 0, 0, 0, 0);
        send_word(CMD_WRITE, 1023, COORD_TOP, COORD_TOP, 0, 0);
        send_word(CMD_WRITE, 500, COORD_TOP, 0, 0, 0);
        send_word(CMD_WRITE, 501, 0, COORD_TOP, 0, 0);
        send_word(CMD_QUERY, 0, 0, 0, 0, 1023);
        send_word(CMD_QUERY, 0, COORD_TOP, COORD_TOP, 0, 1023);
        send_word(CMD_QUERY, 0, COORD_TOP, 0, 0, 1023);
        send_word(CMD_QUERY, 0, 0, COORD_TOP, 1023, 1023);
        send_word(CMD_QUERY, 0, 5, 7, 900, 10);
        send_word(CMD_QUERY, 0, 5, 7, 2, 499);
        send_word(CMD_QUERY, 0, 1, 2, 500, 501);
        send_word(CMD_WRITE, 1023, 3, 9, 0, 0);
        send_word(CMD_QUERY, 0, 0, 0, 1000, 1023);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_count(counts[p]);
            // Write and query at the top index, out of range when the count is below 1024
            send_word(CMD_WRITE, 10'h3FF, 12, 34, 0, 0);
            send_word(CMD_QUERY, 0, 12, 34, 0, 10'h3FF);
            for (int i = 0; i < per_phase[p]; i++) begin
                steady_mode = (p == 4 && i < 150);
                if (p == 3 && i == 100) holdoff_cycles = 400;
                if (p == 0 && i == 200) drain();
                send_random();
            end
            steady_mode = 1'b0;
            drain();
        end

        $display("Covered %0d writes and %0d queries over six point counts (0, 1, 37,",
                 writes_sent, queries_sent);
        $display("1024, 2047) with stalls on both sides; %0d results checked.", sb.checked);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.pending_q.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Timeout guard
    initial begin
        #8_000_000;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/rmmd_pkg.sv
rtl/core/rmmd_ctrl.sv
rtl/core/rmmd_dp.sv
rtl/core/range_max_manhattan_distance_core.sv
verif/range_max_manhattan_distance_core_tb.sv
